>>> rtl/core/dtl_pkg.sv
package dtl_pkg;

  localparam int unsigned DefSlotCount = 16;
  localparam int unsigned DefUnitLimit = 8;

  localparam int unsigned PtrW = 8;
  localparam logic [PtrW-1:0] EndMark = 8'hFF;
  localparam logic [31:0] HalfRange = 32'h7FFF_FFFF;
  localparam logic [31:0] WaitNone = 32'hFFFF_FFFF;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_ARM    = 3'd1;
  localparam logic [2:0] CMD_CANCEL = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_EXPIRE = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ERR  = 2'd1;
  localparam logic [1:0] STAT_BUSY = 2'd2;

  typedef logic [PtrW-1:0] ptr_t;

  typedef struct packed {
    logic [31:0] dl;
    logic [3:0]  unit;
    logic [7:0]  arg;
    ptr_t        nxt;
  } slot_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  unit;
    logic [7:0]  arg;
    logic [31:0] dl;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  count;
    logic [31:0] wait_time;
    logic [3:0]  ex_unit;
    logic [7:0]  ex_arg;
    logic [31:0] ex_dl;
  } res_t;

  typedef struct packed {
    logic  re;
    ptr_t  raddr;
    logic  we;
    ptr_t  waddr;
    slot_t wdata;
  } mem_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CK, ST_SCAN_END,
    ST_UL_RD, ST_UL_CK, ST_UW_RD, ST_UW_CK, ST_UL_END,
    ST_LK_RD, ST_LK_CK, ST_LK_WS, ST_LK_WP,
    ST_EX_RD, ST_EX_CK, ST_HD_RD, ST_HD_CK, ST_DONE
  } seq_state_e;

  function automatic logic precedes(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff > HalfRange;
  endfunction

endpackage

>>> rtl/core/deadline_timeout_list_core.sv
// expire: the popped head needs no list walk
// arm and cancel: key scan over every slot, then list walks over the visited slots
// the slot memory takes one access per cycle, a read or a write, never both
// one item at a time; the next item is taken while the last result waits in its register
// reset clears the list, armed bits, count and time; slot memory needs no clearing pass
module deadline_timeout_list_core #(
  parameter int unsigned SLOT_COUNT = dtl_pkg::DefSlotCount,
  parameter int unsigned UNIT_LIMIT = dtl_pkg::DefUnitLimit
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd, unit_id, unit_arg, deadline_time, now_time, zero pad
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status_code, armed_count, wait_time, expired_unit, expired_arg, expired_deadline, zero pad
  output logic [87:0] m_axis_tdata
);
  import dtl_pkg::*;

  req_t     req;
  res_t     res;
  mem_req_t mem_req;
  slot_t    rdata;
  logic     seq_ready, seq_done, start;
  logic     out_valid_q, out_valid_d;
  res_t     out_q, out_d;

  assign req.cmd  = s_axis_tdata[2:0];
  assign req.unit = s_axis_tdata[6:3];
  assign req.arg  = s_axis_tdata[14:7];
  assign req.dl   = s_axis_tdata[46:15];
  assign req.now  = s_axis_tdata[78:47];

  assign s_axis_tready = seq_ready;
  assign start         = s_axis_tvalid & seq_ready;

  dtl_seq #(
    .SLOT_COUNT(SLOT_COUNT),
    .UNIT_LIMIT(UNIT_LIMIT)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req),
    .ready_o    (seq_ready),
    .res_free_i (!out_valid_q || m_axis_tready),
    .done_o     (seq_done),
    .res_o      (res),
    .mem_o      (mem_req),
    .rdata_i    (rdata)
  );

  dtl_slot_mem #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (seq_done) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.ex_dl, out_q.ex_arg, out_q.ex_unit,
                          out_q.wait_time, out_q.count, out_q.status};

endmodule

>>> rtl/core/dtl_slot_mem.sv
module dtl_slot_mem #(
  parameter int unsigned SLOT_COUNT = dtl_pkg::DefSlotCount
) (
  input  logic             clk_i,
  input  dtl_pkg::mem_req_t req_i,
  output dtl_pkg::slot_t   rdata_o
);
  import dtl_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  slot_t mem_q [SLOT_COUNT];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[IW-1:0]] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[IW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/dtl_seq.sv
module dtl_seq #(
  parameter int unsigned SLOT_COUNT = dtl_pkg::DefSlotCount,
  parameter int unsigned UNIT_LIMIT = dtl_pkg::DefUnitLimit
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dtl_pkg::req_t     req_i,
  output logic              ready_o,
  input  logic              res_free_i,
  output logic              done_o,
  output dtl_pkg::res_t     res_o,
  output dtl_pkg::mem_req_t mem_o,
  input  dtl_pkg::slot_t    rdata_i
);
  import dtl_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOT_COUNT - 1);

  seq_state_e state_q, state_d;

  req_t                  req_q, req_d;
  logic [SLOT_COUNT-1:0] armed_q, armed_d;
  ptr_t                  head_q, head_d;
  logic [7:0]            count_q, count_d;
  logic [31:0]           time_q, time_d;
  logic [IW-1:0]         cnt_q, cnt_d;
  logic                  found_q, found_d;
  logic                  free_q, free_d;
  ptr_t                  found_idx_q, found_idx_d;
  ptr_t                  free_idx_q, free_idx_d;
  ptr_t                  s_q, s_d;
  ptr_t                  snext_q, snext_d;
  ptr_t                  cur_q, cur_d;
  ptr_t                  prev_q, prev_d;
  slot_t                 prev_ent_q, prev_ent_d;
  res_t                  res_q, res_d;

  logic unit_ok;
  ptr_t cnt_ptr;
  assign unit_ok = (req_q.unit != 4'd0) && ({28'd0, req_q.unit} < 32'(UNIT_LIMIT));
  assign cnt_ptr = PtrW'(cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (req_i.cmd)
            CMD_ARM, CMD_CANCEL: state_d = ST_SCAN_RD;
            CMD_EXPIRE:          state_d = (head_q == EndMark) ? ST_HD_RD : ST_EX_RD;
            default:             state_d = ST_HD_RD;
          endcase
        end
      end
      ST_SCAN_RD:  state_d = unit_ok ? ST_SCAN_CK : ST_HD_RD;
      ST_SCAN_CK:  state_d = (cnt_q == LastIdx) ? ST_SCAN_END : ST_SCAN_RD;
      ST_SCAN_END: begin
        if (found_q) begin
          state_d = ST_UL_RD;
        end else if (req_q.cmd == CMD_ARM && free_q) begin
          state_d = ST_LK_RD;
        end else begin
          state_d = ST_HD_RD;
        end
      end
      ST_UL_RD:    state_d = ST_UL_CK;
      ST_UL_CK:    state_d = (head_q == s_q) ? ST_UL_END : ST_UW_RD;
      ST_UW_RD:    state_d = (cur_q == EndMark) ? ST_UL_END : ST_UW_CK;
      ST_UW_CK:    state_d = (rdata_i.nxt == s_q) ? ST_UL_END : ST_UW_RD;
      ST_UL_END:   state_d = (req_q.cmd == CMD_ARM) ? ST_LK_RD : ST_HD_RD;
      ST_LK_RD:    state_d = (cur_q == EndMark) ? ST_LK_WS : ST_LK_CK;
      ST_LK_CK:    state_d = precedes(req_q.dl, rdata_i.dl) ? ST_LK_WS : ST_LK_RD;
      ST_LK_WS:    state_d = (prev_q == EndMark) ? ST_HD_RD : ST_LK_WP;
      ST_LK_WP:    state_d = ST_HD_RD;
      ST_EX_RD:    state_d = ST_EX_CK;
      ST_EX_CK:    state_d = precedes(time_q, rdata_i.dl) ? ST_HD_RD : ST_UL_END;
      ST_HD_RD:    state_d = (head_q == EndMark) ? ST_DONE : ST_HD_CK;
      ST_HD_CK:    state_d = ST_DONE;
      ST_DONE:     state_d = res_free_i ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // memory control and handshake
  always_comb begin
    mem_o   = '0;
    ready_o = (state_q == ST_IDLE);
    done_o  = (state_q == ST_DONE) && res_free_i;
    case (state_q)
      ST_SCAN_RD: begin
        mem_o.re    = unit_ok;
        mem_o.raddr = cnt_ptr;
      end
      ST_UL_RD: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = s_q;
      end
      ST_UW_RD, ST_LK_RD: begin
        mem_o.re    = (cur_q != EndMark);
        mem_o.raddr = cur_q;
      end
      ST_UW_CK: begin
        mem_o.we        = (rdata_i.nxt == s_q);
        mem_o.waddr     = cur_q;
        mem_o.wdata     = rdata_i;
        mem_o.wdata.nxt = snext_q;
      end
      ST_LK_WS: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = s_q;
        mem_o.wdata = '{dl: req_q.dl, unit: req_q.unit, arg: req_q.arg, nxt: cur_q};
      end
      ST_LK_WP: begin
        mem_o.we        = 1'b1;
        mem_o.waddr     = prev_q;
        mem_o.wdata     = prev_ent_q;
        mem_o.wdata.nxt = s_q;
      end
      ST_EX_RD, ST_HD_RD: begin
        mem_o.re    = (head_q != EndMark);
        mem_o.raddr = head_q;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    req_d       = req_q;
    armed_d     = armed_q;
    head_d      = head_q;
    count_d     = count_q;
    time_d      = time_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    free_d      = free_q;
    found_idx_d = found_idx_q;
    free_idx_d  = free_idx_q;
    s_d         = s_q;
    snext_d     = snext_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    prev_ent_d  = prev_ent_q;
    res_d       = res_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d        = req_i;
          cnt_d        = '0;
          found_d      = 1'b0;
          free_d       = 1'b0;
          res_d.status = STAT_ERR;
          res_d.ex_unit = '0;
          res_d.ex_arg  = '0;
          res_d.ex_dl   = '0;
          case (req_i.cmd)
            CMD_CLEAR: begin
              armed_d      = '0;
              head_d       = EndMark;
              count_d      = '0;
              time_d       = '0;
              res_d.status = STAT_OK;
            end
            CMD_TICK: begin
              time_d       = req_i.now;
              res_d.status = STAT_OK;
            end
            CMD_EXPIRE: res_d.status = STAT_BUSY;
            default: ;
          endcase
        end
      end
      ST_SCAN_CK: begin
        if (armed_q[cnt_q] && rdata_i.unit == req_q.unit && rdata_i.arg == req_q.arg
            && !found_q) begin
          found_d     = 1'b1;
          found_idx_d = cnt_ptr;
        end
        if (!armed_q[cnt_q] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = cnt_ptr;
        end
        cnt_d = cnt_q + 1'b1;
      end
      ST_SCAN_END: begin
        prev_d = EndMark;
        cur_d  = head_q;
        if (found_q) begin
          s_d = found_idx_q;
        end else if (req_q.cmd == CMD_ARM && free_q) begin
          s_d                          = free_idx_q;
          armed_d[free_idx_q[IW-1:0]]  = 1'b1;
          count_d                      = count_q + 8'd1;
        end else begin
          res_d.status = STAT_BUSY;
        end
      end
      ST_UL_CK: begin
        snext_d = rdata_i.nxt;
        cur_d   = head_q;
        if (head_q == s_q) begin
          head_d = rdata_i.nxt;
        end
      end
      ST_UW_CK: begin
        cur_d = rdata_i.nxt;
      end
      ST_UL_END: begin
        prev_d = EndMark;
        cur_d  = head_q;
        if (req_q.cmd != CMD_ARM) begin
          armed_d[s_q[IW-1:0]] = 1'b0;
          count_d              = count_q - 8'd1;
          res_d.status         = STAT_OK;
        end
      end
      ST_LK_CK: begin
        if (!precedes(req_q.dl, rdata_i.dl)) begin
          prev_d     = cur_q;
          prev_ent_d = rdata_i;
          cur_d      = rdata_i.nxt;
        end
      end
      ST_LK_WS: begin
        if (prev_q == EndMark) begin
          head_d = s_q;
        end
        res_d.status = STAT_OK;
      end
      ST_EX_CK: begin
        if (!precedes(time_q, rdata_i.dl)) begin
          res_d.ex_unit = rdata_i.unit;
          res_d.ex_arg  = rdata_i.arg;
          res_d.ex_dl   = rdata_i.dl;
          s_d           = head_q;
          head_d        = rdata_i.nxt;
        end
      end
      ST_HD_RD: begin
        res_d.count     = count_q;
        res_d.wait_time = WaitNone;
      end
      ST_HD_CK: begin
        res_d.wait_time = precedes(time_q, rdata_i.dl) ? (rdata_i.dl - time_q) : 32'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      armed_q <= '0;
      head_q  <= EndMark;
      count_q <= '0;
      time_q  <= '0;
    end else begin
      state_q <= state_d;
      armed_q <= armed_d;
      head_q  <= head_d;
      count_q <= count_d;
      time_q  <= time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    cnt_q       <= cnt_d;
    found_q     <= found_d;
    free_q      <= free_d;
    found_idx_q <= found_idx_d;
    free_idx_q  <= free_idx_d;
    s_q         <= s_d;
    snext_q     <= snext_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    prev_ent_q  <= prev_ent_d;
    res_q       <= res_d;
  end

  assign res_o = res_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 8'($countones(armed_q)))
    else $error("armed count out of step with armed slots");

  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> ((head_q == EndMark) == (count_q == 8'd0)))
    else $error("list head disagrees with armed count");

  a_mem_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_o.re && mem_o.we))
    else $error("read and write issued together");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> ready_o)
    else $error("sequencer not idle after result");

endmodule
